FILE: hdl/sgs_pkg.sv
// Shared types, constants and sizing for the Savitzky-Golay smoother.
// Used by every module under hdl; depends on nothing else.
`default_nettype none

package sgs_pkg;

  // Sample format: signed Q2.(SAMPLE_BITS-2).
  localparam int SAMPLE_BITS = 18;
  localparam longint ONE_L = longint'(1) << (SAMPLE_BITS - 2);

  // Window and kernel (-3, 12, 17, 12, -3) / 35.
  localparam int WIN_LEN = 5;
  localparam int SEEN_BITS = $clog2(WIN_LEN + 1);
  localparam int KERNEL_DIV = 35;
  localparam int ROUND_HALF = KERNEL_DIV / 2;

  // Kernel sum width: the absolute coefficients add up to 47, below 64.
  localparam int SUM_BITS = SAMPLE_BITS + 6;
  // Smallest kernel sum whose rounded quotient exceeds 1.0.
  localparam longint CLAMP_SUM_L = longint'(KERNEL_DIV) * ONE_L + ROUND_HALF + 1;

  // Division by 35 as a multiply by a scaled reciprocal. The dividend is the
  // rounded sum below the clamp, under 35 * 1.0 + 35, so it fits in
  // SAMPLE_BITS + 4 bits; six extra fraction bits keep the quotient exact.
  localparam int QUO_BITS = SAMPLE_BITS - 1;
  localparam int DIVIDEND_BITS = SAMPLE_BITS + 4;
  localparam int RECIP_SHIFT = DIVIDEND_BITS + 6;
  localparam longint RECIP_L =
    ((longint'(1) << RECIP_SHIFT) + longint'(KERNEL_DIV) - 1) / longint'(KERNEL_DIV);
  localparam int RECIP_BITS = RECIP_SHIFT - 5;
  localparam int PROD_BITS = DIVIDEND_BITS + RECIP_BITS;

  // Back end pipeline depth from issue to result queue write.
  localparam int PIPE_DEPTH = 4;
  localparam int OUT_DEPTH = 2 ** $clog2(PIPE_DEPTH + 4);
  localparam int OUT_AW = $clog2(OUT_DEPTH);
  localparam int CREDIT_BITS = $clog2(OUT_DEPTH + 1);

  // Job queue between front and back.
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW = $clog2(JOBQ_DEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } in_item_t;

  typedef struct packed {
    sample_t value;
    logic    last_res;
  } out_item_t;

  // Result positions within a window. For smoothed output they pick the tap
  // pattern; for a short sequence they index the raw sample to pass out.
  typedef enum logic [2:0] {
    STEP_HEAD0 = 3'd0,
    STEP_HEAD1 = 3'd1,
    STEP_MID   = 3'd2,
    STEP_TAIL0 = 3'd3,
    STEP_TAIL1 = 3'd4
  } step_t;

  // One unit of work for the back end: a window snapshot and a step range.
  typedef struct packed {
    logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] win;
    logic                                pass;
    step_t                               start;
    step_t                               stop;
  } job_t;

  // Side information that travels down the arithmetic pipeline.
  typedef struct packed {
    sample_t raw;
    logic    last;
    logic    pass;
    logic    zero;
    logic    clamp;
  } side_t;

endpackage

`default_nettype wire

FILE: hdl/sgs_front.sv
// Front end: accepts samples, keeps the sliding window and sequence count,
// and turns each sample that releases results into a job. Uses sgs_pkg.
`default_nettype none

module sgs_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire sgs_pkg::in_item_t item,
  output logic                  job_push,
  output sgs_pkg::job_t         job
);

  logic [sgs_pkg::WIN_LEN-1:0][sgs_pkg::SAMPLE_BITS-1:0] win;
  logic [sgs_pkg::WIN_LEN-1:0][sgs_pkg::SAMPLE_BITS-1:0] win_next;
  logic [sgs_pkg::SEEN_BITS-1:0] seen;
  logic [sgs_pkg::SEEN_BITS-1:0] seen_inc;
  logic                          first_full;

  // Shift the new sample in, oldest entry at index zero.
  always_comb begin
    for (int i = 0; i < sgs_pkg::WIN_LEN - 1; i++) begin
      win_next[i] = win[i+1];
    end
    win_next[sgs_pkg::WIN_LEN-1] = item.sample;
  end

  assign first_full = (seen == sgs_pkg::SEEN_BITS'(sgs_pkg::WIN_LEN - 1));
  assign seen_inc = (seen == sgs_pkg::SEEN_BITS'(sgs_pkg::WIN_LEN)) ?
                    seen : seen + sgs_pkg::SEEN_BITS'(1);

  // Classify the sample into the range of results it releases.
  always_comb begin
    job.win = win_next;
    if (seen_inc < sgs_pkg::SEEN_BITS'(sgs_pkg::WIN_LEN)) begin
      // Short sequence: pass the samples held so far out unchanged.
      job.pass  = 1'b1;
      job.start = sgs_pkg::step_t'(3'(sgs_pkg::WIN_LEN) - 3'(seen_inc));
      job.stop  = sgs_pkg::STEP_TAIL1;
      job_push  = accept && item.last;
    end else begin
      job.pass  = 1'b0;
      job.start = first_full ? sgs_pkg::STEP_HEAD0 : sgs_pkg::STEP_MID;
      job.stop  = item.last ? sgs_pkg::STEP_TAIL1 : sgs_pkg::STEP_MID;
      job_push  = accept;
    end
  end

  // Sequence count; a last sample starts the next sequence afresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= item.last ? '0 : seen_inc;
    end
  end

  // Window entries are only read once the count shows them filled.
  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sgs_jobq.sv
// Short job queue that decouples the front end from the back end.
// Uses sgs_pkg for the job type and depth.
`default_nettype none

module sgs_jobq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sgs_pkg::job_t din,
  output logic               full,
  input  wire logic          pop,
  output sgs_pkg::job_t      dout,
  output logic               empty
);

  sgs_pkg::job_t                  slots [sgs_pkg::JOBQ_DEPTH];
  logic [sgs_pkg::JOBQ_AW-1:0]    wr_ptr;
  logic [sgs_pkg::JOBQ_AW-1:0]    rd_ptr;
  logic [sgs_pkg::JOBQ_AW:0]      count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == (sgs_pkg::JOBQ_AW + 1)'(sgs_pkg::JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + sgs_pkg::JOBQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + sgs_pkg::JOBQ_AW'(1);
      end
      count <= count + (sgs_pkg::JOBQ_AW + 1)'(do_push) - (sgs_pkg::JOBQ_AW + 1)'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sgs_resq.sv
// Result queue at the output. Space is reserved by the back end's credit
// counter before each result is issued, so it never overflows. Uses sgs_pkg.
`default_nettype none

module sgs_resq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sgs_pkg::out_item_t din,
  input  wire logic              pop,
  output sgs_pkg::out_item_t     dout,
  output logic                   empty
);

  sgs_pkg::out_item_t             slots [sgs_pkg::OUT_DEPTH];
  logic [sgs_pkg::OUT_AW-1:0]     wr_ptr;
  logic [sgs_pkg::OUT_AW-1:0]     rd_ptr;
  logic [sgs_pkg::CREDIT_BITS-1:0] count;
  logic                           do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = slots[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sgs_pkg::OUT_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + sgs_pkg::OUT_AW'(1);
      end
      count <= count + sgs_pkg::CREDIT_BITS'(push) - sgs_pkg::CREDIT_BITS'(do_pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sgs_back.sv
// Back end: steps through each job one result per cycle while the result
// queue has room, runs the kernel, rounding division by 35 and clamp in a
// pipeline and writes the result queue; uses sgs_pkg, instantiates sgs_resq.
`default_nettype none

module sgs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_empty,
  input  wire sgs_pkg::job_t job_in,
  output logic               job_pop,
  input  wire logic          pop,
  output sgs_pkg::out_item_t result,
  output logic               empty
);

  localparam int B  = sgs_pkg::SAMPLE_BITS;
  localparam logic signed [sgs_pkg::SUM_BITS-1:0] CLAMP_SUM =
    sgs_pkg::SUM_BITS'(sgs_pkg::CLAMP_SUM_L);
  localparam logic signed [sgs_pkg::SUM_BITS-1:0] ROUND_ADD =
    sgs_pkg::SUM_BITS'(sgs_pkg::ROUND_HALF);
  localparam logic signed [sgs_pkg::SUM_BITS-1:0] ZERO_SUM = '0;
  localparam logic [sgs_pkg::RECIP_BITS-1:0] RECIP =
    sgs_pkg::RECIP_BITS'(sgs_pkg::RECIP_L);
  localparam logic [B-1:0] ONE_VAL = B'(sgs_pkg::ONE_L);

  // Current job and step.
  logic           busy;
  sgs_pkg::job_t  cur;
  sgs_pkg::step_t step;
  logic           issue;
  logic           load;
  logic [sgs_pkg::CREDIT_BITS-1:0] credit;
  logic           res_pop;
  logic           res_push;
  sgs_pkg::out_item_t res_din;

  // Tap selection.
  sgs_pkg::sample_t ta, tb, tc, td, te, raw;

  // Pipeline registers.
  logic                              v1;
  logic signed [B:0]                 bd1;
  logic signed [B:0]                 ae1;
  sgs_pkg::sample_t                  c1;
  sgs_pkg::side_t                    side1;
  logic                              v2;
  logic signed [sgs_pkg::SUM_BITS-1:0] s2;
  logic signed [sgs_pkg::SUM_BITS-1:0] s2_next;
  logic signed [sgs_pkg::SUM_BITS-1:0] bdx, aex, cx;
  sgs_pkg::side_t                    side2;
  logic                              v3;
  logic [sgs_pkg::DIVIDEND_BITS-1:0] num3;
  sgs_pkg::side_t                    side3;
  logic                              v4;
  logic [sgs_pkg::PROD_BITS-1:0]     prod4;
  sgs_pkg::side_t                    side4;
  logic [sgs_pkg::QUO_BITS-1:0]      quo;

  // Issue a result when a job is active and the result queue has room.
  assign issue   = busy && (credit < sgs_pkg::CREDIT_BITS'(sgs_pkg::OUT_DEPTH));
  assign load    = !job_empty && (!busy || (issue && step == cur.stop));
  assign job_pop = load;
  assign res_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (issue && step == cur.stop) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= job_in;
      step <= job_in.start;
    end else if (issue) begin
      step <= sgs_pkg::step_t'(step + 3'd1);
    end
  end

  // Credits count results issued and not yet taken from the result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + sgs_pkg::CREDIT_BITS'(issue) - sgs_pkg::CREDIT_BITS'(res_pop);
    end
  end

  // Tap patterns, mirrored about the end samples at head and tail.
  always_comb begin
    case (step)
      sgs_pkg::STEP_HEAD0: begin
        ta = cur.win[2]; tb = cur.win[1]; tc = cur.win[0]; td = cur.win[1]; te = cur.win[2];
        raw = cur.win[0];
      end
      sgs_pkg::STEP_HEAD1: begin
        ta = cur.win[1]; tb = cur.win[0]; tc = cur.win[1]; td = cur.win[2]; te = cur.win[3];
        raw = cur.win[1];
      end
      sgs_pkg::STEP_TAIL0: begin
        ta = cur.win[1]; tb = cur.win[2]; tc = cur.win[3]; td = cur.win[4]; te = cur.win[3];
        raw = cur.win[3];
      end
      sgs_pkg::STEP_TAIL1: begin
        ta = cur.win[2]; tb = cur.win[3]; tc = cur.win[4]; td = cur.win[3]; te = cur.win[2];
        raw = cur.win[4];
      end
      default: begin
        ta = cur.win[0]; tb = cur.win[1]; tc = cur.win[2]; td = cur.win[3]; te = cur.win[4];
        raw = cur.win[2];
      end
    endcase
  end

  // Stage 1: fold the symmetric taps.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    bd1        <= (B + 1)'(tb) + (B + 1)'(td);
    ae1        <= (B + 1)'(ta) + (B + 1)'(te);
    c1         <= tc;
    side1.raw  <= raw;
    side1.last <= (step == sgs_pkg::STEP_TAIL1);
    side1.pass <= cur.pass;
    side1.zero <= 1'b0;
    side1.clamp <= 1'b0;
  end

  // Stage 2: kernel sum 12*(b+d) - 3*(a+e) + 17*c by shifts and adds.
  assign bdx = sgs_pkg::SUM_BITS'(bd1);
  assign aex = sgs_pkg::SUM_BITS'(ae1);
  assign cx  = sgs_pkg::SUM_BITS'(c1);
  assign s2_next = (bdx <<< 3) + (bdx <<< 2) - (aex <<< 1) - aex + (cx <<< 4) + cx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s2    <= s2_next;
    side2 <= side1;
  end

  // Stage 3: classify the sum and add the rounding offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    num3        <= sgs_pkg::DIVIDEND_BITS'(s2 + ROUND_ADD);
    side3.raw   <= side2.raw;
    side3.last  <= side2.last;
    side3.pass  <= side2.pass;
    side3.zero  <= (s2 <= ZERO_SUM);
    side3.clamp <= (s2 >= CLAMP_SUM);
  end

  // Stage 4: divide by 35 through the scaled reciprocal. The quotient is
  // only used when the sum lies between the zero floor and the clamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    prod4 <= sgs_pkg::PROD_BITS'(num3) * sgs_pkg::PROD_BITS'(RECIP);
    side4 <= side3;
  end

  assign quo = prod4[sgs_pkg::RECIP_SHIFT +: sgs_pkg::QUO_BITS];

  // Final selection: raw passthrough, zero floor, 1.0 ceiling or quotient.
  always_comb begin
    res_push         = v4;
    res_din.last_res = side4.last;
    if (side4.pass) begin
      res_din.value = side4.raw;
    end else if (side4.zero) begin
      res_din.value = '0;
    end else if (side4.clamp) begin
      res_din.value = ONE_VAL;
    end else begin
      res_din.value = B'(quo);
    end
  end

  sgs_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_din),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

FILE: hdl/savitzky_golay_smoother.sv
// Five-tap Savitzky-Golay smoother, kernel (-3, 12, 17, 12, -3) / 35, with
// mirrored edges, round to nearest and clamp to 0..1.0 on signed Q2.16
// samples. The input side takes one sample per cycle whenever the job queue
// has room; the back end issues one result per cycle while the result queue
// has room, so in steady flow a sample and a result move every cycle. A
// sequence end releases up to five results, which the back end issues one
// per cycle while the front keeps taking samples into its four-entry job
// queue. A result is ready to pop once its releasing sample has passed the
// job queue, the back end's job register, three arithmetic stages, the
// reciprocal multiply stage and the result queue write. A sequence of fewer
// than five samples passes out raw on its last sample.
// Depends on sgs_pkg, sgs_front, sgs_jobq and sgs_back.
`default_nettype none

module savitzky_golay_smoother (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire sgs_pkg::in_item_t item,
  output logic                   empty,
  input  wire logic              pop,
  output sgs_pkg::out_item_t     result
);

  logic          accept;
  logic          job_push;
  sgs_pkg::job_t job_new;
  logic          job_pop;
  sgs_pkg::job_t job_head;
  logic          job_empty;

  // A transaction is taken whenever the job queue has room.
  assign accept = push && !full;

  sgs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_new)
  );

  sgs_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_new),
    .full  (full),
    .pop   (job_pop),
    .dout  (job_head),
    .empty (job_empty)
  );

  sgs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_in    (job_head),
    .job_pop   (job_pop),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

endmodule

`default_nettype wire
